### rtl/qesr_pkg.sv
// ----------------------------------------------------------------------------
// qesr_pkg - shared types, constants and arithmetic helpers
// Fixed-point formats, register indexes and pipeline structs for the Q4
// element strain recovery pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package qesr_pkg;

	// Integration scheme
	localparam int GAUSS_POINTS_PER_AXIS = 2;
	localparam int NPTS  = GAUSS_POINTS_PER_AXIS * GAUSS_POINTS_PER_AXIS;
	localparam int NLANE = 2 * NPTS;   // one x and one y quotient per point
	localparam int NNODE = 4;
	localparam int NFLD  = 4;
	localparam int NDIR  = 2;

	// Field and direction indexes
	localparam int FLD_CX  = 0;
	localparam int FLD_CY  = 1;
	localparam int FLD_UX  = 2;
	localparam int FLD_UY  = 3;
	localparam int DIR_XI  = 0;
	localparam int DIR_ETA = 1;

	// round(2^28/sqrt(3))
	localparam logic signed [28:0] GAUSS_Q28 = 29'sd154981283;

	// Quotient: integer part below 2^22, 18 fraction bits
	localparam int OVF_SHIFT  = 22;
	localparam int FRAC_SHIFT = 18;
	localparam int QBITS      = OVF_SHIFT + FRAC_SHIFT;

	// Register indexes
	typedef enum logic [2:0] {
		REG_NODE0 = 3'd0,
		REG_NODE1 = 3'd1,
		REG_NODE2 = 3'd2,
		REG_NODE3 = 3'd3,
		REG_RATIO = 3'd4
	} cfg_idx_t;

	// Register reset values
	localparam logic [63:0] NODE0_RST = 64'h0000_0000_0000_0000;
	localparam logic [63:0] NODE1_RST = 64'h0001_0000_0000_0000;
	localparam logic [63:0] NODE2_RST = 64'h0001_0000_0001_0000;
	localparam logic [63:0] NODE3_RST = 64'h0000_0000_0001_0000;
	localparam logic [30:0] RATIO_RST = 31'd357913941;

	typedef logic signed [31:0] word_t;

	// Sideband carried alongside the data
	typedef struct packed {
		logic            last;
		logic [NPTS-1:0] degen;
	} side_t;

	// One division job: magnitudes and result sign
	typedef struct packed {
		logic [63:0] num;
		logic [63:0] den;
		logic        neg;
	} div_job_t;

	// One division result
	typedef struct packed {
		logic [QBITS-1:0] mag;
		logic             neg;
		logic             ovf;
	} div_res_t;

	// Saturate to the 32-bit signed range
	function automatic word_t sat32(input logic signed [63:0] v);
		if (v > 64'sh0000_0000_7fff_ffff) begin
			return 32'sh7fff_ffff;
		end else if (v < -64'sh0000_0000_8000_0000) begin
			return -32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	// Divide by 2^30, round to nearest, ties away from zero
	function automatic logic signed [63:0] rnd_q30(input logic signed [63:0] v);
		logic signed [63:0] t;
		t = v + (v[63] ? 64'sd536870911 : 64'sd536870912);
		return t >>> 30;
	endfunction

endpackage

`default_nettype wire

### rtl/qesr_deriv.sv
// ----------------------------------------------------------------------------
// qesr_deriv - shape-derivative pipeline
// Forms the xi and eta derivatives of the node coordinates and the nodal
// displacements at both Gauss signs, rounded and saturated to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module qesr_deriv (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            vld_in,
	input  qesr_pkg::word_t w [qesr_pkg::NFLD][qesr_pkg::NNODE],
	input  logic            last_in,
	output logic            vld_out,
	output qesr_pkg::word_t rate [qesr_pkg::NFLD][qesr_pkg::NDIR][qesr_pkg::GAUSS_POINTS_PER_AXIS],
	output logic            last_out
);
	import qesr_pkg::*;

	logic signed [33:0] axi_s1 [NFLD];
	logic signed [33:0] aeta_s1 [NFLD];
	logic signed [33:0] h_s1 [NFLD];
	logic signed [33:0] axi_s2 [NFLD];
	logic signed [33:0] aeta_s2 [NFLD];
	logic signed [62:0] hg_s2 [NFLD];
	logic signed [63:0] full_s3 [NFLD][NDIR][GAUSS_POINTS_PER_AXIS];
	word_t              rate_s4 [NFLD][NDIR][GAUSS_POINTS_PER_AXIS];
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic last_s1, last_s2, last_s3, last_s4;

	// Valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (en) begin
			last_s1 <= last_in;
			last_s2 <= last_s1;
			last_s3 <= last_s2;
			last_s4 <= last_s3;
			for (int f = 0; f < NFLD; f++) begin
				// stage 1: node combinations
				axi_s1[f]  <= -34'(w[f][0]) + 34'(w[f][1]) + 34'(w[f][2]) - 34'(w[f][3]);
				aeta_s1[f] <= -34'(w[f][0]) - 34'(w[f][1]) + 34'(w[f][2]) + 34'(w[f][3]);
				h_s1[f]    <= 34'(w[f][0]) - 34'(w[f][1]) + 34'(w[f][2]) - 34'(w[f][3]);
				// stage 2: bilinear term times g
				axi_s2[f]  <= axi_s1[f];
				aeta_s2[f] <= aeta_s1[f];
				hg_s2[f]   <= h_s1[f] * GAUSS_Q28;
				// stage 3: exact sums at both signs
				for (int s = 0; s < GAUSS_POINTS_PER_AXIS; s++) begin
					full_s3[f][DIR_XI][s] <= (64'(axi_s2[f]) <<< 28) +
						((s == 1) ? 64'(hg_s2[f]) : -64'(hg_s2[f]));
					full_s3[f][DIR_ETA][s] <= (64'(aeta_s2[f]) <<< 28) +
						((s == 1) ? 64'(hg_s2[f]) : -64'(hg_s2[f]));
				end
				// stage 4: round and saturate
				for (int d = 0; d < NDIR; d++) begin
					for (int s = 0; s < GAUSS_POINTS_PER_AXIS; s++) begin
						rate_s4[f][d][s] <= sat32(rnd_q30(full_s3[f][d][s]));
					end
				end
			end
		end
	end

	assign rate     = rate_s4;
	assign vld_out  = vld_s4;
	assign last_out = last_s4;

endmodule

`default_nettype wire

### rtl/qesr_point.sv
// ----------------------------------------------------------------------------
// qesr_point - per Gauss point Jacobian products
// Forms the determinant and both strain numerators at each point and
// hands sign-magnitude division jobs to the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module qesr_point (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               vld_in,
	input  qesr_pkg::word_t    rate [qesr_pkg::NFLD][qesr_pkg::NDIR][qesr_pkg::GAUSS_POINTS_PER_AXIS],
	input  logic               last_in,
	output logic               vld_out,
	output qesr_pkg::div_job_t job [qesr_pkg::NLANE],
	output qesr_pkg::side_t    side_out
);
	import qesr_pkg::*;

	logic signed [63:0] prod_s1 [NPTS][6];
	logic signed [64:0] det_s2 [NPTS];
	logic signed [64:0] numx_s2 [NPTS];
	logic signed [64:0] numy_s2 [NPTS];
	logic signed [64:0] dabs [NPTS];
	logic signed [64:0] xabs [NPTS];
	logic signed [64:0] yabs [NPTS];
	div_job_t           job_s3 [NLANE];
	side_t              side_s3;
	logic vld_s1, vld_s2, vld_s3;
	logic last_s1, last_s2;

	// Valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Magnitudes of determinant and numerators
	always_comb begin
		for (int p = 0; p < NPTS; p++) begin
			dabs[p] = det_s2[p][64] ? -det_s2[p] : det_s2[p];
			xabs[p] = numx_s2[p][64] ? -numx_s2[p] : numx_s2[p];
			yabs[p] = numy_s2[p][64] ? -numy_s2[p] : numy_s2[p];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_s1 <= last_in;
			last_s2 <= last_s1;
			side_s3.last <= last_s2;
			for (int p = 0; p < NPTS; p++) begin
				// stage 1: products; xi sign from the point row, eta sign from its column
				prod_s1[p][0] <= rate[FLD_CX][DIR_XI][p % GAUSS_POINTS_PER_AXIS] *
					rate[FLD_CY][DIR_ETA][p / GAUSS_POINTS_PER_AXIS];
				prod_s1[p][1] <= rate[FLD_CY][DIR_XI][p % GAUSS_POINTS_PER_AXIS] *
					rate[FLD_CX][DIR_ETA][p / GAUSS_POINTS_PER_AXIS];
				prod_s1[p][2] <= rate[FLD_CY][DIR_ETA][p / GAUSS_POINTS_PER_AXIS] *
					rate[FLD_UX][DIR_XI][p % GAUSS_POINTS_PER_AXIS];
				prod_s1[p][3] <= rate[FLD_CY][DIR_XI][p % GAUSS_POINTS_PER_AXIS] *
					rate[FLD_UX][DIR_ETA][p / GAUSS_POINTS_PER_AXIS];
				prod_s1[p][4] <= rate[FLD_CX][DIR_XI][p % GAUSS_POINTS_PER_AXIS] *
					rate[FLD_UY][DIR_ETA][p / GAUSS_POINTS_PER_AXIS];
				prod_s1[p][5] <= rate[FLD_CX][DIR_ETA][p / GAUSS_POINTS_PER_AXIS] *
					rate[FLD_UY][DIR_XI][p % GAUSS_POINTS_PER_AXIS];
				// stage 2: differences
				det_s2[p]  <= 65'(prod_s1[p][0]) - 65'(prod_s1[p][1]);
				numx_s2[p] <= 65'(prod_s1[p][2]) - 65'(prod_s1[p][3]);
				numy_s2[p] <= 65'(prod_s1[p][4]) - 65'(prod_s1[p][5]);
				// stage 3: sign-magnitude jobs
				job_s3[2*p].num   <= xabs[p][63:0];
				job_s3[2*p].den   <= dabs[p][63:0];
				job_s3[2*p].neg   <= numx_s2[p][64] ^ det_s2[p][64];
				job_s3[2*p+1].num <= yabs[p][63:0];
				job_s3[2*p+1].den <= dabs[p][63:0];
				job_s3[2*p+1].neg <= numy_s2[p][64] ^ det_s2[p][64];
				side_s3.degen[p]  <= (det_s2[p] == 65'sd0);
			end
		end
	end

	assign job      = job_s3;
	assign side_out = side_s3;
	assign vld_out  = vld_s3;

endmodule

`default_nettype wire

### rtl/qesr_div.sv
// ----------------------------------------------------------------------------
// qesr_div - pipelined restoring divider, all lanes
// Computes num*2^18/den truncated, one quotient bit per stage, with an
// overflow flag when the integer part reaches 2^22.
// ----------------------------------------------------------------------------
`default_nettype none

module qesr_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               vld_in,
	input  qesr_pkg::div_job_t job [qesr_pkg::NLANE],
	input  qesr_pkg::side_t    side_in,
	output logic               vld_out,
	output qesr_pkg::div_res_t res [qesr_pkg::NLANE],
	output qesr_pkg::side_t    side_out
);
	import qesr_pkg::*;

	localparam int NST = QBITS + 1;

	// index is the stage: entry register, then one per quotient bit
	logic [63:0]      rem_s [NST][NLANE];
	logic [QBITS-1:0] tq_s  [NST][NLANE];   // dividend tail shifting out, quotient in
	logic [63:0]      den_s [NST][NLANE];
	logic             neg_s [NST][NLANE];
	logic             ovf_s [NST][NLANE];
	side_t            side_s [NST];
	logic             vld_s [NST];

	logic [64:0] trial [1:QBITS][NLANE];
	logic [64:0] diff  [1:QBITS][NLANE];

	// Trial subtraction for each stage
	always_comb begin
		for (int k = 1; k < NST; k++) begin
			for (int l = 0; l < NLANE; l++) begin
				trial[k][l] = {rem_s[k-1][l], tq_s[k-1][l][QBITS-1]};
				diff[k][l]  = trial[k][l] - {1'b0, den_s[k-1][l]};
			end
		end
	end

	// Valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NST; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= vld_in;
			for (int k = 1; k < NST; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// entry: top bits as first remainder, overflow check
			side_s[0] <= side_in;
			for (int l = 0; l < NLANE; l++) begin
				rem_s[0][l] <= 64'(job[l].num >> OVF_SHIFT);
				tq_s[0][l]  <= {job[l].num[OVF_SHIFT-1:0], FRAC_SHIFT'(0)};
				den_s[0][l] <= job[l].den;
				neg_s[0][l] <= job[l].neg;
				ovf_s[0][l] <= 64'(job[l].num >> OVF_SHIFT) >= job[l].den;
			end
			// one quotient bit per stage
			for (int k = 1; k < NST; k++) begin
				side_s[k] <= side_s[k-1];
				for (int l = 0; l < NLANE; l++) begin
					den_s[k][l] <= den_s[k-1][l];
					neg_s[k][l] <= neg_s[k-1][l];
					ovf_s[k][l] <= ovf_s[k-1][l];
					if (!diff[k][l][64]) begin
						rem_s[k][l] <= diff[k][l][63:0];
						tq_s[k][l]  <= {tq_s[k-1][l][QBITS-2:0], 1'b1};
					end else begin
						rem_s[k][l] <= trial[k][l][63:0];
						tq_s[k][l]  <= {tq_s[k-1][l][QBITS-2:0], 1'b0};
					end
				end
			end
		end
	end

	always_comb begin
		for (int l = 0; l < NLANE; l++) begin
			res[l].mag = tq_s[QBITS][l];
			res[l].neg = neg_s[QBITS][l];
			res[l].ovf = ovf_s[QBITS][l];
		end
	end

	assign vld_out  = vld_s[QBITS];
	assign side_out = side_s[QBITS];

endmodule

`default_nettype wire

### rtl/qesr_avg.sv
// ----------------------------------------------------------------------------
// qesr_avg - averaging and out-of-plane strain
// Signs and caps the point quotients, averages them, saturates, forms
// ezz from the Poisson factor and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module qesr_avg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               vld_in,
	input  qesr_pkg::div_res_t res [qesr_pkg::NLANE],
	input  qesr_pkg::side_t    side_in,
	input  logic [30:0]        ratio,
	output logic               vld_out,
	output qesr_pkg::word_t    exx,
	output qesr_pkg::word_t    eyy,
	output qesr_pkg::word_t    ezz,
	output logic               degen,
	output logic               last
);
	import qesr_pkg::*;

	localparam int QW = QBITS + 2;   // signed quotient, cap of 2^40 included
	localparam int SW = QW + 2;      // sum of the points

	logic signed [QW-1:0] q_s1 [NLANE];
	logic signed [SW-1:0] sx_s2, sy_s2;
	logic signed [SW-1:0] sx_nxt, sy_nxt;
	logic signed [SW-1:0] tx, ty;
	word_t                exx_s3, eyy_s3, exx_s4, eyy_s4, exx_s5, eyy_s5;
	logic signed [32:0]   esum_s4;
	logic signed [63:0]   prod_s5;
	word_t                exx_s6, eyy_s6, ezz_s6;
	logic degen_s1, degen_s2, degen_s3, degen_s4, degen_s5, degen_s6;
	logic last_s1, last_s2, last_s3, last_s4, last_s5, last_s6;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	// Point sums, x lanes even and y lanes odd
	always_comb begin
		sx_nxt = '0;
		sy_nxt = '0;
		for (int p = 0; p < NPTS; p++) begin
			sx_nxt = sx_nxt + SW'(q_s1[2*p]);
			sy_nxt = sy_nxt + SW'(q_s1[2*p+1]);
		end
		// divide by four, toward zero
		tx = sx_s2 + (sx_s2[SW-1] ? SW'(3) : SW'(0));
		ty = sy_s2 + (sy_s2[SW-1] ? SW'(3) : SW'(0));
	end

	// Valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1: signed, capped quotients
			for (int l = 0; l < NLANE; l++) begin
				if (res[l].ovf) begin
					q_s1[l] <= res[l].neg ? -(QW'(1) <<< QBITS) : (QW'(1) <<< QBITS);
				end else begin
					q_s1[l] <= res[l].neg ? -$signed({1'b0, res[l].mag}) :
						$signed({1'b0, res[l].mag});
				end
			end
			degen_s1 <= |side_in.degen;
			last_s1  <= side_in.last;
			// stage 2: sums
			sx_s2    <= sx_nxt;
			sy_s2    <= sy_nxt;
			degen_s2 <= degen_s1;
			last_s2  <= last_s1;
			// stage 3: average and saturate
			exx_s3   <= sat32(64'(tx >>> 2));
			eyy_s3   <= sat32(64'(ty >>> 2));
			degen_s3 <= degen_s2;
			last_s3  <= last_s2;
			// stage 4: in-plane sum
			esum_s4  <= 33'(exx_s3) + 33'(eyy_s3);
			exx_s4   <= exx_s3;
			eyy_s4   <= eyy_s3;
			degen_s4 <= degen_s3;
			last_s4  <= last_s3;
			// stage 5: Poisson factor
			prod_s5  <= $signed({1'b0, ratio}) * esum_s4;
			exx_s5   <= exx_s4;
			eyy_s5   <= eyy_s4;
			degen_s5 <= degen_s4;
			last_s5  <= last_s4;
			// stage 6: output register, degenerate elements read zero
			exx_s6   <= degen_s5 ? '0 : exx_s5;
			eyy_s6   <= degen_s5 ? '0 : eyy_s5;
			ezz_s6   <= degen_s5 ? '0 : sat32(-rnd_q30(prod_s5));
			degen_s6 <= degen_s5;
			last_s6  <= last_s5;
		end
	end

	assign vld_out = vld_s6;
	assign exx     = exx_s6;
	assign eyy     = eyy_s6;
	assign ezz     = ezz_s6;
	assign degen   = degen_s6;
	assign last    = last_s6;

endmodule

`default_nettype wire

### rtl/quad_element_strain_recovery.sv
// ----------------------------------------------------------------------------
// quad_element_strain_recovery - Q4 element strain recovery, 2x2 Gauss
// Streams one element per cycle while the output is taken and returns its averaged strains.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one element per transaction:
//   eight Q8.24 nodal displacements and a last-element mark. Output channel
//   (out_valid/out_ready) returns strain_xx, strain_yy, strain_zz in Q6.26,
//   the degenerate flag and last_out for that element, in order.
//   Node coordinates and the Poisson factor are written through cfg_we,
//   cfg_idx and cfg_data, only while the pipeline is empty: the user
//   must keep to this, the block does not enforce it. Throughput: one
//   element per clock cycle when the output is taken.
//   The pipeline holds 54 register stages: the restoring divider (one
//   quotient bit per stage, 40 stages plus entry) and 13 stages of
//   derivative, product and averaging logic.
//   Reset clears every valid bit and loads the unit-square coordinates and
//   the default factor. A stalled receiver freezes the whole pipeline, the
//   result stays in the output register and in_ready drops until it is
//   taken; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module quad_element_strain_recovery (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] disp_x0,
	input  logic [31:0] disp_y0,
	input  logic [31:0] disp_x1,
	input  logic [31:0] disp_y1,
	input  logic [31:0] disp_x2,
	input  logic [31:0] disp_y2,
	input  logic [31:0] disp_x3,
	input  logic [31:0] disp_y3,
	input  logic        last_element,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] strain_xx,
	output logic [31:0] strain_yy,
	output logic [31:0] strain_zz,
	output logic        degenerate,
	output logic        last_out,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [63:0] cfg_data
);
	import qesr_pkg::*;

	logic [63:0] node_q [NNODE];
	logic [30:0] ratio_q;
	logic        adv;

	word_t    w [NFLD][NNODE];
	word_t    rate [NFLD][NDIR][GAUSS_POINTS_PER_AXIS];
	div_job_t job [NLANE];
	div_res_t res [NLANE];
	side_t    side_pt, side_dv;
	logic     vld_dr, vld_pt, vld_dv;
	logic     last_dr;
	word_t    exx, eyy, ezz;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_q[0] <= NODE0_RST;
			node_q[1] <= NODE1_RST;
			node_q[2] <= NODE2_RST;
			node_q[3] <= NODE3_RST;
			ratio_q   <= RATIO_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_idx))
				REG_NODE0: node_q[0] <= cfg_data;
				REG_NODE1: node_q[1] <= cfg_data;
				REG_NODE2: node_q[2] <= cfg_data;
				REG_NODE3: node_q[3] <= cfg_data;
				REG_RATIO: ratio_q   <= cfg_data[30:0];
				default:   ;
			endcase
		end
	end

	// Global advance: the pipeline moves unless a result is held
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// Field gather: coordinates from registers, displacements from the port
	always_comb begin
		for (int k = 0; k < NNODE; k++) begin
			w[FLD_CX][k] = node_q[k][63:32];
			w[FLD_CY][k] = node_q[k][31:0];
		end
		w[FLD_UX][0] = disp_x0;
		w[FLD_UY][0] = disp_y0;
		w[FLD_UX][1] = disp_x1;
		w[FLD_UY][1] = disp_y1;
		w[FLD_UX][2] = disp_x2;
		w[FLD_UY][2] = disp_y2;
		w[FLD_UX][3] = disp_x3;
		w[FLD_UY][3] = disp_y3;
	end

	qesr_deriv u_deriv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.vld_in   (in_valid),
		.w        (w),
		.last_in  (last_element),
		.vld_out  (vld_dr),
		.rate     (rate),
		.last_out (last_dr)
	);

	qesr_point u_point (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.vld_in   (vld_dr),
		.rate     (rate),
		.last_in  (last_dr),
		.vld_out  (vld_pt),
		.job      (job),
		.side_out (side_pt)
	);

	qesr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.vld_in   (vld_pt),
		.job      (job),
		.side_in  (side_pt),
		.vld_out  (vld_dv),
		.res      (res),
		.side_out (side_dv)
	);

	qesr_avg u_avg (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.vld_in  (vld_dv),
		.res     (res),
		.side_in (side_dv),
		.ratio   (ratio_q),
		.vld_out (out_valid),
		.exx     (exx),
		.eyy     (eyy),
		.ezz     (ezz),
		.degen   (degenerate),
		.last    (last_out)
	);

	assign strain_xx = exx;
	assign strain_yy = eyy;
	assign strain_zz = ezz;

	// Degenerate elements carry zero strains
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> strain_xx == '0 && strain_yy == '0 && strain_zz == '0)
		else $error("degenerate result with non-zero strain");

	// A zero factor gives no out-of-plane strain
	a_ratio_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ratio_q == '0 |-> strain_zz == '0)
		else $error("strain_zz non-zero with zero factor");

	// No in-plane strain means no out-of-plane strain
	a_plane_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && strain_xx == '0 && strain_yy == '0 |-> strain_zz == '0)
		else $error("strain_zz non-zero without in-plane strain");

endmodule

`default_nettype wire

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - Q4 element strain recovery testbench
// Drives elements through the valid/ready input, predicts the averaged
// strains of each in a behavioural model of the 2x2 Gauss scheme and checks
// every output transaction in order. Node geometry and the Poisson factor
// are changed between phases, including degenerate and saturating shapes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	import qesr_pkg::*;

	localparam int PIPE_LAT = 54;
	localparam logic signed [63:0] GQ = 64'sd154981283;

	typedef struct packed {
		logic [31:0] sxx;
		logic [31:0] syy;
		logic [31:0] szz;
		logic        degen;
		logic        last;
	} strain_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] disp [8];
	logic        last_element = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] strain_xx, strain_yy, strain_zz;
	logic        degenerate, last_out;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_idx = '0;
	logic [63:0] cfg_data = '0;

	// Shadow copy of the configuration
	logic [63:0] node_xy [4];
	logic [30:0] ratio;

	strain_t expected_strains [$];
	int      n_err = 0;
	int      n_elem = 0;
	int      n_degen = 0;
	int      n_cfg = 0;
	bit      quiet = 1'b0;

	initial for (int k = 0; k < 8; k++) disp[k] = '0;

	quad_element_strain_recovery dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.disp_x0(disp[0]), .disp_y0(disp[1]), .disp_x1(disp[2]), .disp_y1(disp[3]),
		.disp_x2(disp[4]), .disp_y2(disp[5]), .disp_x3(disp[6]), .disp_y3(disp[7]),
		.last_element(last_element),
		.out_valid(out_valid), .out_ready(out_ready),
		.strain_xx(strain_xx), .strain_yy(strain_yy), .strain_zz(strain_zz),
		.degenerate(degenerate), .last_out(last_out),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	// Clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ---------------- behavioural strain model ----------------
	function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic logic signed [63:0] div_q30(input logic signed [63:0] v);
		logic [63:0] m;
		m = v < 0 ? -v : v;
		m = (m + 64'd536870912) >> 30;
		return v < 0 ? -$signed(m) : $signed(m);
	endfunction

	// Shape-function derivative of four nodal values
	function automatic logic signed [63:0] shape_rate(input logic signed [63:0] w [4],
			input int s, input bit on_eta);
		logic signed [63:0] a, h;
		a = on_eta ? (-w[0] - w[1] + w[2] + w[3]) : (-w[0] + w[1] + w[2] - w[3]);
		h = w[0] - w[1] + w[2] - w[3];
		return clamp32(div_q30(a * 64'sd268435456 + s * h * GQ));
	endfunction

	// num*2^18/den, truncated, magnitude capped at 2^40
	function automatic logic signed [63:0] gauss_quot(input logic signed [63:0] num,
			input logic signed [63:0] den);
		logic [63:0] n, d, q, r;
		logic signed [63:0] mag;
		n = num < 0 ? -num : num;
		d = den < 0 ? -den : den;
		q = n / d;
		r = n % d;
		if (q >= 64'd4194304) begin
			mag = 64'sd1099511627776;
		end else begin
			for (int k = 0; k < 18; k++) begin
				r = r << 1;
				q = q << 1;
				if (r >= d) begin
					r = r - d;
					q[0] = 1'b1;
				end
			end
			mag = $signed(q);
		end
		return ((num < 0) != (den < 0)) ? -mag : mag;
	endfunction

	function automatic strain_t element_strain(input logic [31:0] u [8], input logic lst);
		logic signed [63:0] cx [4], cy [4], ux [4], uy [4];
		logic signed [63:0] j00, j01, j10, j11, dud, due, dvd, dve, det;
		logic signed [63:0] sx, sy, exx, eyy, ezz;
		strain_t r;
		bit dg;
		int sxi, seta;
		sx = 0;
		sy = 0;
		dg = 0;
		exx = 0;
		eyy = 0;
		ezz = 0;
		for (int k = 0; k < 4; k++) begin
			cx[k] = $signed(node_xy[k][63:32]);
			cy[k] = $signed(node_xy[k][31:0]);
			ux[k] = $signed(u[2*k]);
			uy[k] = $signed(u[2*k+1]);
		end
		for (int i = 0; i < 2; i++) begin
			for (int j = 0; j < 2; j++) begin
				sxi = i == 0 ? -1 : 1;
				seta = j == 0 ? -1 : 1;
				j00 = shape_rate(cx, seta, 0);
				j01 = shape_rate(cy, seta, 0);
				j10 = shape_rate(cx, sxi, 1);
				j11 = shape_rate(cy, sxi, 1);
				dud = shape_rate(ux, seta, 0);
				due = shape_rate(ux, sxi, 1);
				dvd = shape_rate(uy, seta, 0);
				dve = shape_rate(uy, sxi, 1);
				det = j00 * j11 - j01 * j10;
				if (det == 0) begin
					dg = 1;
				end else begin
					sx += gauss_quot(j11 * dud - j01 * due, det);
					sy += gauss_quot(j00 * dve - j10 * dvd, det);
				end
			end
		end
		if (!dg) begin
			exx = clamp32(sx / 4);
			eyy = clamp32(sy / 4);
			ezz = clamp32(-div_q30($signed({33'd0, ratio}) * (exx + eyy)));
		end
		r.sxx = exx[31:0];
		r.syy = eyy[31:0];
		r.szz = ezz[31:0];
		r.degen = dg;
		r.last = lst;
		return r;
	endfunction

	// ---------------- drivers ----------------
	task automatic write_reg(input cfg_idx_t idx, input logic [63:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_RATIO) ratio = val[30:0];
		else node_xy[idx] = val;
		n_cfg++;
	endtask

	// Wait for the pipeline to drain before touching registers
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_strains.size() != 0) @(negedge clk);
		repeat (PIPE_LAT + 4) @(negedge clk);
	endtask

	task automatic set_geometry(input logic [63:0] n0, n1, n2, n3);
		drain();
		write_reg(REG_NODE0, n0);
		write_reg(REG_NODE1, n1);
		write_reg(REG_NODE2, n2);
		write_reg(REG_NODE3, n3);
	endtask

	// Send one element; valid held until accepted, dropped only when idling
	task automatic send_element(input logic [31:0] u [8], input logic lst);
		if (!quiet && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		for (int k = 0; k < 8; k++) disp[k] <= u[k];
		last_element <= lst;
		in_valid <= 1'b1;
		expected_strains.push_back(element_strain(u, lst));
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		n_elem++;
		@(negedge clk);
	endtask

	function automatic logic [31:0] rand_disp(input int mode);
		case (mode)
			0: return $urandom();
			1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			default: return $signed($urandom_range(0, 2**22)) - 32'sd2097152;
		endcase
	endfunction

	task automatic random_elements(input int n);
		logic [31:0] u [8];
		int mode;
		for (int e = 0; e < n; e++) begin
			mode = $urandom_range(0, 9) < 6 ? 2 : ($urandom_range(0, 4) == 0 ? 1 : 0);
			for (int k = 0; k < 8; k++) u[k] = rand_disp(mode);
			send_element(u, $urandom_range(0, 1));
		end
	endtask

	// ---------------- result checker ----------------
	always @(posedge clk) begin
		strain_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (expected_strains.size() == 0) begin
				n_err++;
				if (n_err <= 10) $display("unexpected transaction xx=%h", strain_xx);
			end else begin
				exp_r = expected_strains.pop_front();
				if (exp_r.degen) n_degen++;
				if (exp_r != {strain_xx, strain_yy, strain_zz, degenerate, last_out}) begin
					n_err++;
					if (n_err <= 10)
						$display("mismatch: exp xx=%h yy=%h zz=%h dg=%b l=%b got xx=%h yy=%h zz=%h dg=%b l=%b",
							exp_r.sxx, exp_r.syy, exp_r.szz, exp_r.degen, exp_r.last,
							strain_xx, strain_yy, strain_zz, degenerate, last_out);
				end
			end
		end
	end

	// Receiver stalls in bursts
	initial begin
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// ---------------- tests ----------------
	task automatic test_extremes();
		logic [31:0] u [8];
		for (int t = 0; t < 12; t++) begin
			for (int k = 0; k < 8; k++)
				case (t % 4)
					0: u[k] = '0;
					1: u[k] = 32'h7fffffff;
					2: u[k] = 32'h80000000;
					default: u[k] = (k + t) % 2 ? 32'h7fffffff : 32'h80000000;
				endcase
			if (t >= 4) u[t % 8] = t < 8 ? 32'h01000000 : 32'hff000000;
			send_element(u, t[0]);
		end
	endtask

	task automatic test_ratio_extremes();
		drain();
		write_reg(REG_RATIO, 64'd0);
		random_elements(4);
		drain();
		write_reg(REG_RATIO, 64'h7fffffff);
		random_elements(6);
		drain();
		write_reg(REG_RATIO, 64'd1073741824);
		random_elements(4);
	endtask

	task automatic test_degenerate();
		// All nodes coincident: every determinant zero
		set_geometry(64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000,
			64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000);
		random_elements(5);
		// Collinear nodes along x
		set_geometry(64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000,
			64'h0002_0000_0000_0000, 64'h0003_0000_0000_0000);
		random_elements(5);
	endtask

	task automatic test_saturated_jacobian();
		set_geometry(64'h8000_0000_8000_0000, 64'h7fff_ffff_8000_0000,
			64'h7fff_ffff_7fff_ffff, 64'h8000_0000_7fff_ffff);
		random_elements(10);
		// Tiny element to push strains into saturation
		set_geometry(64'h0000_0000_0000_0000, 64'h0000_0001_0000_0000,
			64'h0000_0001_0000_0001, 64'h0000_0000_0000_0001);
		random_elements(10);
	endtask

	task automatic test_ignored_index();
		drain();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= 3'd7;
		cfg_data <= {$urandom(), $urandom()};
		@(negedge clk);
		cfg_idx <= 3'd5;
		@(negedge clk);
		cfg_we <= 1'b0;
		random_elements(5);
	endtask

	task automatic test_random_geometry();
		logic [63:0] n [4];
		for (int p = 0; p < 12; p++) begin
			for (int k = 0; k < 4; k++) begin
				if (p % 3 == 0)
					n[k] = {$urandom(), $urandom()};
				else
					n[k] = {32'($signed($urandom_range(0, 2**20)) - 32'sd524288),
						32'($signed($urandom_range(0, 2**20)) - 32'sd524288)};
			end
			set_geometry(n[0], n[1], n[2], n[3]);
			drain();
			write_reg(REG_RATIO, {33'd0, 31'($urandom())});
			random_elements(120);
		end
	endtask

	task automatic test_unit_square_stream();
		set_geometry(NODE0_RST, NODE1_RST, NODE2_RST, NODE3_RST);
		drain();
		write_reg(REG_RATIO, {33'd0, RATIO_RST});
		random_elements(300);
		quiet = 1'b1;
		random_elements(200);
	endtask

	initial begin
		node_xy[0] = NODE0_RST;
		node_xy[1] = NODE1_RST;
		node_xy[2] = NODE2_RST;
		node_xy[3] = NODE3_RST;
		ratio = RATIO_RST;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		test_extremes();
		test_ratio_extremes();
		test_degenerate();
		test_saturated_jacobian();
		test_ignored_index();
		test_random_geometry();
		test_unit_square_stream();
		in_valid <= 1'b0;
		while (expected_strains.size() != 0) @(negedge clk);
		repeat (PIPE_LAT + 10) @(negedge clk);
		$display("covered %0d elements (%0d degenerate) over %0d register writes",
			n_elem, n_degen, n_cfg);
		$display("geometries: unit square, random, coincident, collinear, saturating, tiny");
		if (n_err == 0) begin
			$display("tb_top OK");
		end else begin
			$display("%0d mismatches", n_err);
			$display("tb_top NOT OK");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#20000000;
		$display("timeout");
		$display("tb_top NOT OK");
		$finish;
	end

endmodule

`default_nettype wire

### sim.f
rtl/qesr_pkg.sv
rtl/qesr_deriv.sv
rtl/qesr_point.sv
rtl/qesr_div.sv
rtl/qesr_avg.sv
rtl/quad_element_strain_recovery.sv
verif/tb_top.sv
